[rtl/core/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    // Default width of the payload length counter
    localparam int LEN_BITS_DEF = 64;

    // Header field positions and codes
    localparam int       HDR_FLAG_BIT = 7;       // fin in byte 0, mask in byte 1
    localparam int       OPCODE_BITS  = 4;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [2:0] KEY_BYTES    = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]             payload_byte;
        logic                   byte_valid;
        logic                   frame_end;
        logic                   final_fragment;
        logic [OPCODE_BITS-1:0] frame_opcode;
    } t_result;

endpackage

[rtl/core/wsd_parser.sv]
// Frame header parser and payload unmasking, one word per cycle while i_accept is high.
`timescale 1ns / 1ps

module wsd_parser #(
    parameter int LENGTH_BITS = wsd_pkg::LEN_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic                   r_fin, n_fin;
    logic [OPCODE_BITS-1:0] r_opcode, n_opcode;
    logic                   r_mask_on, n_mask_on;
    logic [3:0]             r_ext_left, n_ext_left;
    logic [2:0]             r_key_left, n_key_left;
    logic [31:0]            r_key, n_key;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [1:0]             r_idx, n_idx;

    logic       length_done;
    logic       start_pl;
    logic       emit;
    logic [7:0] key_byte;

    // key byte for the current payload position, first key byte in [31:24]
    always_comb begin
        unique case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_mask_on   = r_mask_on;
        n_ext_left  = r_ext_left;
        n_key_left  = r_key_left;
        n_key       = r_key;
        n_len       = r_len;
        n_idx       = r_idx;
        length_done = 1'b0;
        start_pl    = 1'b0;
        emit        = 1'b0;
        o_res.payload_byte   = '0;
        o_res.byte_valid     = 1'b0;
        o_res.frame_end      = 1'b0;
        o_res.final_fragment = r_fin;
        o_res.frame_opcode   = r_opcode;

        unique case (r_phase)
            PH_HDR1: begin
                n_mask_on = i_rx_byte[HDR_FLAG_BIT];
                if (i_rx_byte[6:0] == LEN_CODE_16) begin
                    n_len      = '0;
                    n_ext_left = EXT_BYTES_16;
                    n_phase    = PH_EXT;
                end else if (i_rx_byte[6:0] == LEN_CODE_64) begin
                    n_len      = '0;
                    n_ext_left = EXT_BYTES_64;
                    n_phase    = PH_EXT;
                end else begin
                    n_len       = {{(LENGTH_BITS-7){1'b0}}, i_rx_byte[6:0]};
                    length_done = 1'b1;
                end
            end
            PH_EXT: begin
                // big-endian, wraps to LENGTH_BITS
                n_len      = {r_len[LENGTH_BITS-9:0], i_rx_byte};
                n_ext_left = r_ext_left - 4'd1;
                length_done = (n_ext_left == 4'd0);
            end
            PH_KEY: begin
                n_key      = {r_key[23:0], i_rx_byte};
                n_key_left = r_key_left - 3'd1;
                start_pl   = (n_key_left == 3'd0);
            end
            PH_DATA: begin
                emit                 = 1'b1;
                o_res.byte_valid     = 1'b1;
                o_res.payload_byte   = r_mask_on ? (i_rx_byte ^ key_byte) : i_rx_byte;
                n_idx                = r_idx + 2'd1;
                n_len                = r_len - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                if (r_len == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
                    o_res.frame_end = 1'b1;
                    n_phase         = PH_HDR0;
                end
            end
            default: begin
                // first header byte; unused phase codes land here too
                n_fin    = i_rx_byte[HDR_FLAG_BIT];
                n_opcode = i_rx_byte[OPCODE_BITS-1:0];
                n_phase  = PH_HDR1;
            end
        endcase

        if (length_done) begin
            if (n_mask_on) begin
                n_key_left = KEY_BYTES;
                n_phase    = PH_KEY;
            end else begin
                start_pl = 1'b1;
            end
        end

        if (start_pl) begin
            n_idx = 2'd0;
            if (n_len == '0) begin
                // empty frame: close it with a byteless result
                emit            = 1'b1;
                o_res.frame_end = 1'b1;
                n_phase         = PH_HDR0;
            end else begin
                n_phase = PH_DATA;
            end
        end

        o_res_valid = i_accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_mask_on  <= 1'b0;
            r_ext_left <= '0;
            r_key_left <= '0;
            r_idx      <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_mask_on  <= n_mask_on;
            r_ext_left <= n_ext_left;
            r_key_left <= n_key_left;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_key    <= n_key;
            r_len    <= n_len;
        end
    end

endmodule

[rtl/core/websocket_frame_deframer.sv]
// Top level: WebSocket frame deframer with registered, skid-buffered result port.
`timescale 1ns / 1ps
// Throughput: one received word per cycle while o_stall is low, header words included.
// Result path: a result is written to the output register when the word that causes it is accepted,
//   or to the skid entry if the output is stalled (parser logic feeds the output register directly).
// o_stall comes only from the skid register; a single stalled result never blocks input.
// Reset (i_rst_n low, synchronous): parser back to the first header word, output empty.

module websocket_frame_deframer #(
    parameter int LENGTH_BITS = wsd_pkg::LEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // received byte stream
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result words
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_byte_valid,
    output logic       o_frame_end,
    output logic       o_final_fragment,
    output logic [3:0] o_frame_opcode
);
    import wsd_pkg::*;

    logic    in_accept;
    logic    res_valid;
    t_result res;

    // output register plus one skid entry
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    t_result r_skid, n_skid;
    logic    r_skid_valid, n_skid_valid;
    logic    out_take;

    // input is held off only while the skid entry is occupied
    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;

    wsd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        out_take     = r_out_valid && !i_stall;

        if (r_skid_valid) begin
            // no new word accepted; drain skid into output when it frees up
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                // output stalled: park the new result
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid          = r_out_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_byte_valid     = r_out.byte_valid;
    assign o_frame_end      = r_out.frame_end;
    assign o_final_fragment = r_out.final_fragment;
    assign o_frame_opcode   = r_out.frame_opcode;

endmodule

[rtl/core/wsd_checker.sv]
// Port-level assertions for the WebSocket frame deframer, bound to the top level.
`timescale 1ns / 1ps

module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_payload_byte,
    input logic       o_byte_valid,
    input logic       o_frame_end,
    input logic       o_final_fragment,
    input logic [3:0] o_frame_opcode
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte)
            && $stable(o_byte_valid) && $stable(o_frame_end)
            && $stable(o_final_fragment) && $stable(o_frame_opcode))
        else $error("result word changed while stalled");

    // a byteless result only closes an empty frame
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_frame_end && (o_payload_byte == 8'd0))
        else $error("byteless result without frame end or with nonzero byte");

    // input is stalled only when the output register is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // reset empties both sides
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
